// ===== rtl/i8sig_pkg.sv =====
// Shared constants and types for the int8 sigmoid activation block.
`default_nettype none
package i8sig_pkg;
    localparam int FRAC_BITS_DEF = 16;
    localparam int CODE_W        = 8;
    localparam int OUT_W         = 7;
    localparam int CFG_W         = 24;
    localparam int CFG_IDX_W     = 1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THX = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_THY = 1'b1;

    localparam logic [CFG_W-1:0] THR_RESET = 24'd65536;

    localparam logic [6:0]       Q_SCALE = 7'd127;
    localparam logic [OUT_W-1:0] OUT_MAX = 7'd127;
    localparam logic [31:0]      LN2_Q32 = 32'd2977044472;
    localparam int               EXP_TERMS = 20;

    // Sigmoid divide: 2^62 or e*2^30 over 2^32 + e
    localparam int SIG_NUM_W = 63;
    localparam int SIG_DEN_W = 34;

    // Per-item data that rides along the exp series stages
    typedef struct packed {
        logic [31:0] rr;
        logic [5:0]  k;
        logic        big;
        logic        neg;
    } t_exp_side;
endpackage
`default_nettype wire

// ===== rtl/int8_sigmoid_activation.sv =====
// Top level of the int8 quantized sigmoid activation pipeline.
//
// Usage:
//  - s_axis carries one signed int8 code per request; m_axis returns the
//    7-bit sigmoid code (0..127), one result per request, in order.
//  - i_cfg_we/i_cfg_addr/i_cfg_wdata write threshold_in (index 0) and
//    threshold_out (index 1), unsigned Q8.16; write only while idle.
//  - Throughput: one request per cycle unless the pipe holds. The pipe is
//    made of the |q|*thx stages, the /127 fold stages, the k = t/ln2 steps,
//    19 series terms at 3 stages each, the 64-stage sigmoid divide, and
//    the output quantizer.
//  - Every stage moves on one shared advance: the pipe holds when the
//    output register is full and m_axis_tready is low, so a stall drops
//    or repeats nothing; s_axis_tready follows the same advance.
//  - Reset (synchronous, active low) empties the pipe and loads both
//    thresholds with 1.0. A zero output threshold gives 127.
`default_nettype none
module int8_sigmoid_activation #(
    parameter int FRAC_BITS = i8sig_pkg::FRAC_BITS_DEF
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  wire logic [7:0]                       s_axis_tdata,  // [7:0] code_in
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    output logic      [7:0]                       m_axis_tdata,  // [6:0] code_out, [7] zero
    input  wire logic                             i_cfg_we,
    input  wire logic [i8sig_pkg::CFG_IDX_W-1:0]  i_cfg_addr,
    input  wire logic [i8sig_pkg::CFG_W-1:0]      i_cfg_wdata
);
    localparam int T_NUM_W = 64 - FRAC_BITS;          // (|q|*thx) << (32-F)
    localparam int NFOLD   = (T_NUM_W + 6) / 7;        // folds to bring t's dividend below 2*127
    localparam int NT      = i8sig_pkg::EXP_TERMS - 1; // terms n = 2..20
    localparam int FIN_W   = (40 + FRAC_BITS > 62) ? 40 + FRAC_BITS : 62;
    localparam logic [T_NUM_W-1:0] BIG_LIM = T_NUM_W'(64'd24 << 32);

    // ---------------- configuration ----------------
    logic [i8sig_pkg::CFG_W-1:0] r_thx;
    logic [i8sig_pkg::CFG_W-1:0] r_thy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thx <= i8sig_pkg::THR_RESET;
            r_thy <= i8sig_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                i8sig_pkg::CFG_THX: r_thx <= i_cfg_wdata;
                i8sig_pkg::CFG_THY: r_thy <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // ---------------- pipe control ----------------
    logic r_out_vld;
    logic w_adv;
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;

    // ---------------- stage 1/2: magnitude and |q|*thx ----------------
    logic        r_s1_vld, r_s2_vld;
    logic [7:0]  r_s1_mag;
    logic        r_s1_neg, r_s2_neg;
    logic [31:0] r_s2_p;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= s_axis_tvalid;
            r_s2_vld <= r_s1_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_neg <= s_axis_tdata[7];
            r_s1_mag <= s_axis_tdata[7] ? 8'(-s_axis_tdata) : s_axis_tdata;
            r_s2_neg <= r_s1_neg;
            r_s2_p   <= 32'(r_s1_mag) * 32'(r_thx);
        end
    end

    // ---------------- t = |x| in Q.32: divide by 127 ----------------
    // 127 = 2^7 - 1, so R = hi*128 + lo = hi*127 + (hi + lo): each fold
    // moves hi into the quotient and keeps hi + lo. After NFOLD folds the
    // remainder is below 2*127 and one compare-subtract finishes it.
    logic               r_d_vld [0:NFOLD];
    logic [T_NUM_W-1:0] r_d_rem [0:NFOLD];
    logic [T_NUM_W-1:0] r_d_quo [0:NFOLD];
    logic               r_d_neg [0:NFOLD];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_d_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_d_vld[0] <= r_s2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_d_rem[0] <= {r_s2_p, {(32-FRAC_BITS){1'b0}}};
            r_d_quo[0] <= '0;
            r_d_neg[0] <= r_s2_neg;
        end
    end

    for (genvar j = 0; j < NFOLD; j++) begin : g_fold
        logic [T_NUM_W-1:0] w_hi;
        logic [T_NUM_W-1:0] w_lo;

        always_comb begin
            w_hi = r_d_rem[j] >> 7;
            w_lo = {{(T_NUM_W-7){1'b0}}, r_d_rem[j][6:0]};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_d_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_d_vld[j+1] <= r_d_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_d_rem[j+1] <= w_hi + w_lo;
                r_d_quo[j+1] <= r_d_quo[j] + w_hi;
                r_d_neg[j+1] <= r_d_neg[j];
            end
        end
    end

    logic               r_t_vld;
    logic [T_NUM_W-1:0] r_t;
    logic               r_t_neg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (w_adv) begin
            r_t_vld <= r_d_vld[NFOLD];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_t     <= (r_d_rem[NFOLD] >= T_NUM_W'(i8sig_pkg::Q_SCALE))
                       ? r_d_quo[NFOLD] + T_NUM_W'(1) : r_d_quo[NFOLD];
            r_t_neg <= r_d_neg[NFOLD];
        end
    end

    // ---------------- k = t / ln2, r = t mod ln2 ----------------
    logic        r_k_vld [0:6];
    logic [36:0] r_k_rem [0:6];
    logic [5:0]  r_k_q   [0:6];
    logic        r_k_big [0:6];
    logic        r_k_neg [0:6];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_k_vld[0] <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_k_big[0] <= r_t >= BIG_LIM;
            r_k_rem[0] <= (r_t >= BIG_LIM) ? 37'd0 : r_t[36:0];
            r_k_q[0]   <= '0;
            r_k_neg[0] <= r_t_neg;
        end
    end

    for (genvar j = 0; j < 6; j++) begin : g_kstep
        logic [36:0] w_cmp;
        logic        w_ge;

        always_comb begin
            w_cmp = 37'(i8sig_pkg::LN2_Q32) << (5 - j);
            w_ge  = r_k_rem[j] >= w_cmp;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_k_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_k_vld[j+1] <= r_k_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_k_rem[j+1] <= w_ge ? r_k_rem[j] - w_cmp : r_k_rem[j];
                r_k_q[j+1]   <= {r_k_q[j][4:0], w_ge};
                r_k_big[j+1] <= r_k_big[j];
                r_k_neg[j+1] <= r_k_neg[j];
            end
        end
    end

    // ---------------- e^-r series, term n = 1 first ----------------
    logic                 r_c_vld  [0:NT];
    logic [31:0]          r_c_term [0:NT];
    logic [32:0]          r_c_sum  [0:NT];
    i8sig_pkg::t_exp_side r_c_side [0:NT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_c_vld[0] <= r_k_vld[6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_c_term[0]      <= r_k_rem[6][31:0];
            r_c_sum[0]       <= (33'd1 << 32) - 33'(r_k_rem[6][31:0]);
            r_c_side[0].rr   <= r_k_rem[6][31:0];
            r_c_side[0].k    <= r_k_q[6];
            r_c_side[0].big  <= r_k_big[6];
            r_c_side[0].neg  <= r_k_neg[6];
        end
    end

    // Each term: multiply by r, reciprocal estimate of /n, one-step correction.
    for (genvar i = 1; i <= NT; i++) begin : g_term
        localparam int          N    = i + 1;
        localparam logic [32:0] RECIP = 33'((66'd1 << 33) / N);
        localparam logic        ODD  = (N % 2) == 1;

        logic                 r_a_vld, r_b_vld;
        logic [31:0]          r_a_x, r_b_x, r_b_q0;
        logic [32:0]          r_a_sum, r_b_sum;
        i8sig_pkg::t_exp_side r_a_side, r_b_side;
        logic [36:0]          w_rem;
        logic [31:0]          w_term;

        always_comb begin
            w_rem  = 37'(r_b_x) - 37'(r_b_q0) * 37'(N);
            w_term = (w_rem >= 37'(N)) ? r_b_q0 + 32'd1 : r_b_q0;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_a_vld    <= 1'b0;
                r_b_vld    <= 1'b0;
                r_c_vld[i] <= 1'b0;
            end else if (w_adv) begin
                r_a_vld    <= r_c_vld[i-1];
                r_b_vld    <= r_a_vld;
                r_c_vld[i] <= r_b_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_a_x       <= 32'((64'(r_c_term[i-1]) * 64'(r_c_side[i-1].rr)) >> 32);
                r_a_sum     <= r_c_sum[i-1];
                r_a_side    <= r_c_side[i-1];
                r_b_q0      <= 32'((65'(r_a_x) * 65'(RECIP)) >> 33);
                r_b_x       <= r_a_x;
                r_b_sum     <= r_a_sum;
                r_b_side    <= r_a_side;
                r_c_term[i] <= w_term;
                r_c_sum[i]  <= ODD ? r_b_sum - 33'(w_term) : r_b_sum + 33'(w_term);
                r_c_side[i] <= r_b_side;
            end
        end
    end

    // ---------------- e = E(r) >> k, sigmoid divide operands ----------------
    logic                                r_e_vld;
    logic [i8sig_pkg::SIG_NUM_W-1:0]     r_e_num;
    logic [i8sig_pkg::SIG_DEN_W-1:0]     r_e_den;
    logic [32:0]                         w_e;

    assign w_e = r_c_side[NT].big ? 33'd0 : (r_c_sum[NT] >> r_c_side[NT].k);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_vld <= 1'b0;
        end else if (w_adv) begin
            r_e_vld <= r_c_vld[NT];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_e_num <= r_c_side[NT].neg ? (63'(w_e) << 30) : (63'd1 << 62);
            r_e_den <= 34'(w_e) + (34'd1 << 32);
        end
    end

    logic                            w_s_vld;
    logic [i8sig_pkg::SIG_NUM_W-1:0] w_s;

    i8sig_divider #(
        .NUM_W (i8sig_pkg::SIG_NUM_W),
        .DEN_W (i8sig_pkg::SIG_DEN_W)
    ) u_sdiv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_valid (r_e_vld),
        .i_num   (r_e_num),
        .i_den   (r_e_den),
        .o_valid (w_s_vld),
        .o_quo   (w_s)
    );

    // ---------------- output quantizer ----------------
    // res = (254*s*2^F + thy*2^30) / (thy*2^31), saturated: an overflow
    // check against 128*den, then seven quotient bits. thy = 0 lands in
    // the overflow arm and gives 127.
    logic             r_fn_vld;
    logic [FIN_W-1:0] r_fn;
    logic             r_f_vld  [0:7];
    logic [FIN_W-1:0] r_f_rem  [0:7];
    logic [6:0]       r_f_q    [0:7];
    logic             r_f_over [0:7];
    logic [6:0]       r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fn_vld   <= 1'b0;
            r_f_vld[0] <= 1'b0;
        end else if (w_adv) begin
            r_fn_vld   <= w_s_vld;
            r_f_vld[0] <= r_fn_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_fn        <= ((FIN_W'(w_s[30:0]) * FIN_W'(254)) << FRAC_BITS)
                           + (FIN_W'(r_thy) << 30);
            r_f_rem[0]  <= r_fn;
            r_f_q[0]    <= '0;
            r_f_over[0] <= r_fn >= (FIN_W'(r_thy) << 38);
        end
    end

    for (genvar j = 0; j < 7; j++) begin : g_fstep
        logic [FIN_W-1:0] w_cmp;
        logic             w_ge;

        always_comb begin
            w_cmp = FIN_W'(r_thy) << (37 - j);
            w_ge  = r_f_rem[j] >= w_cmp;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_f_vld[j+1] <= 1'b0;
            end else if (w_adv) begin
                r_f_vld[j+1] <= r_f_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_f_rem[j+1]  <= w_ge ? r_f_rem[j] - w_cmp : r_f_rem[j];
                r_f_q[j+1]    <= {r_f_q[j][5:0], w_ge};
                r_f_over[j+1] <= r_f_over[j];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= r_f_vld[7];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_data <= r_f_over[7] ? i8sig_pkg::OUT_MAX : r_f_q[7];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {1'b0, r_out_data};
endmodule
`default_nettype wire

// ===== rtl/i8sig_divider.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module i8sig_divider #(
    parameter int NUM_W = i8sig_pkg::SIG_NUM_W,
    parameter int DEN_W = i8sig_pkg::SIG_DEN_W
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_en,
    input  wire logic             i_valid,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_valid,
    output logic      [NUM_W-1:0] o_quo
);
    logic             r_vld [0:NUM_W];
    logic [DEN_W-1:0] r_rem [0:NUM_W];
    logic [NUM_W-1:0] r_quo [0:NUM_W];   // remaining dividend bits, then quotient bits
    logic [DEN_W-1:0] r_den [0:NUM_W];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (i_en) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= '0;
            r_quo[0] <= i_num;
            r_den[0] <= i_den;
        end
    end

    for (genvar j = 0; j < NUM_W; j++) begin : g_step
        logic [DEN_W:0]   w_trial;
        logic [DEN_W:0]   w_diff;
        logic             w_ge;
        logic [DEN_W-1:0] n_rem;
        logic [NUM_W-1:0] n_quo;

        always_comb begin
            w_trial = {r_rem[j], r_quo[j][NUM_W-1]};
            w_diff  = w_trial - {1'b0, r_den[j]};
            w_ge    = w_trial >= {1'b0, r_den[j]};
            n_rem   = w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
            n_quo   = {r_quo[j][NUM_W-2:0], w_ge};
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[j+1] <= 1'b0;
            end else if (i_en) begin
                r_vld[j+1] <= r_vld[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j+1] <= n_rem;
                r_quo[j+1] <= n_quo;
                r_den[j+1] <= r_den[j];
            end
        end
    end

    assign o_valid = r_vld[NUM_W];
    assign o_quo   = r_quo[NUM_W];
endmodule
`default_nettype wire
